// ===== design/swsmm_pkg.sv =====
// shared types and constants for the sliding window sum, min and max core
`default_nettype none
package swsmm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 38;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
	} scan_ctl_t;

endpackage
`default_nettype wire

// ===== design/swsmm_ring.sv =====
// sample ring memory, one write port and one registered read port
`default_nettype none
module swsmm_ring import swsmm_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic signed [SAMPLE_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output logic signed [SAMPLE_W-1:0]      rdata
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/swsmm_scan.sv =====
// shared compare unit that keeps the running max and min over a ring scan
`default_nettype none
module swsmm_scan import swsmm_pkg::*; #(
	parameter int AW = 6
) (
	input  wire logic                       clk,
	input  wire scan_ctl_t                  ctl,
	input  wire logic signed [SAMPLE_W-1:0] value,
	input  wire logic [AW-1:0]              slot,
	output logic signed [SAMPLE_W-1:0]      best_max,
	output logic signed [SAMPLE_W-1:0]      best_min,
	output logic [AW-1:0]                   max_pos,
	output logic [AW-1:0]                   min_pos
);

	logic signed [SAMPLE_W-1:0] best_max_q;
	logic signed [SAMPLE_W-1:0] best_min_q;
	logic [AW-1:0]              max_pos_q;
	logic [AW-1:0]              min_pos_q;
	logic                       take_max;
	logic                       take_min;

	// strict compares keep the lowest slot on ties
	assign take_max = ctl.first || (value > best_max_q);
	assign take_min = ctl.first || (value < best_min_q);

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			if (take_max) begin
				best_max_q <= value;
				max_pos_q  <= slot;
			end
			if (take_min) begin
				best_min_q <= value;
				min_pos_q  <= slot;
			end
		end
	end

	assign best_max = best_max_q;
	assign best_min = best_min_q;
	assign max_pos  = max_pos_q;
	assign min_pos  = min_pos_q;

endmodule
`default_nettype wire

// ===== design/sliding_window_sum_min_max_core.sv =====
// top level: sequencer, running sum and window extremes over a sample ring
//
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   sample
// out       out  out_valid/out_stall window_sum, window_max, window_min,
//                                    max_slot, min_slot, sample_count
// cfg       in   cfg_wr_en           cfg_wr_data (track_extremes)
//
// with no extreme leaving the ring, an accepted item steps through ST_READ and ST_DONE
// with tracking on, when an evicted sample held the max or min and the new one does not
// replace it, one ST_SCAN pass reads all DEPTH slots through the single ring read port
// in_stall is high from accept until the result is loaded in the output register
// out_stall holds a finished beat; the next item is accepted meanwhile
// reset clears control state; unwritten slots read as zero through the fill count
`default_nettype none
module sliding_window_sum_min_max_core import swsmm_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic                       cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [SUM_W-1:0]         window_sum,
	output logic signed [SAMPLE_W-1:0]      window_max,
	output logic signed [SAMPLE_W-1:0]      window_min,
	output logic [SLOT_W-1:0]               max_slot,
	output logic [SLOT_W-1:0]               min_slot,
	output logic [COUNT_W-1:0]              sample_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL      = CW'(DEPTH);

	state_t                     state_q;
	logic                       track_q;
	logic [AW-1:0]              ws_q;
	logic [CW-1:0]              filled_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] cur_max_q;
	logic signed [SAMPLE_W-1:0] cur_min_q;
	logic [AW-1:0]              max_pos_q;
	logic [AW-1:0]              min_pos_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       need_max_q;
	logic                       need_min_q;
	logic [AW-1:0]              scan_addr_q;
	logic                       rd_valid_s1;
	logic                       first_s1;
	logic [AW-1:0]              idx_s1;
	logic                       out_valid_q;
	logic signed [SUM_W-1:0]    out_sum_q;
	logic signed [SAMPLE_W-1:0] out_max_q;
	logic signed [SAMPLE_W-1:0] out_min_q;
	logic [AW-1:0]              out_max_pos_q;
	logic [AW-1:0]              out_min_pos_q;
	logic [CW-1:0]              out_count_q;

	logic                       in_accept;
	logic                       out_free;
	logic [AW-1:0]              next_slot;
	logic                       ring_we;
	logic                       ring_re;
	logic [AW-1:0]              ring_raddr;
	logic signed [SAMPLE_W-1:0] ring_rdata;
	logic signed [SAMPLE_W-1:0] old_val;
	logic signed [SAMPLE_W-1:0] scan_val;
	logic                       take_max;
	logic                       take_min;
	logic                       hit_max;
	logic                       hit_min;
	scan_ctl_t                  scan_ctl;
	logic signed [SAMPLE_W-1:0] best_max;
	logic signed [SAMPLE_W-1:0] best_min;
	logic [AW-1:0]              best_max_pos;
	logic [AW-1:0]              best_min_pos;
	logic signed [SAMPLE_W-1:0] fin_max;
	logic signed [SAMPLE_W-1:0] fin_min;
	logic [AW-1:0]              fin_max_pos;
	logic [AW-1:0]              fin_min_pos;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign next_slot  = (ws_q == LAST_SLOT) ? '0 : ws_q + 1'b1;

	assign ring_we    = (state_q == ST_READ);
	assign ring_re    = in_accept || (state_q == ST_SCAN);
	assign ring_raddr = (state_q == ST_SCAN) ? scan_addr_q : next_slot;

	// slots past the fill count were never written and count as zero
	assign old_val  = (filled_q == FULL) ? ring_rdata : '0;
	assign scan_val = (CW'(idx_s1) < filled_q) ? ring_rdata : '0;

	assign take_max = x_q > cur_max_q;
	assign take_min = x_q < cur_min_q;
	assign hit_max  = old_val == cur_max_q;
	assign hit_min  = old_val == cur_min_q;

	assign scan_ctl.valid = rd_valid_s1;
	assign scan_ctl.first = first_s1;

	assign fin_max     = need_max_q ? best_max : cur_max_q;
	assign fin_min     = need_min_q ? best_min : cur_min_q;
	assign fin_max_pos = need_max_q ? best_max_pos : max_pos_q;
	assign fin_min_pos = need_min_q ? best_min_pos : min_pos_q;

	swsmm_ring #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ws_q),
		.wdata (x_q),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	swsmm_scan #(
		.AW (AW)
	) u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.value    (scan_val),
		.slot     (idx_s1),
		.best_max (best_max),
		.best_min (best_min),
		.max_pos  (best_max_pos),
		.min_pos  (best_min_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			track_q     <= 1'b1;
			ws_q        <= LAST_SLOT;
			filled_q    <= '0;
			sum_q       <= '0;
			cur_max_q   <= '0;
			cur_min_q   <= '0;
			max_pos_q   <= '0;
			min_pos_q   <= '0;
			need_max_q  <= 1'b0;
			need_min_q  <= 1'b0;
			scan_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				track_q <= cfg_wr_data;
			end
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						ws_q    <= next_slot;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (filled_q != FULL) begin
						filled_q <= filled_q + 1'b1;
					end
					sum_q       <= sum_q + SUM_W'(x_q) - SUM_W'(old_val);
					need_max_q  <= 1'b0;
					need_min_q  <= 1'b0;
					scan_addr_q <= '0;
					state_q     <= ST_DONE;
					if (track_q) begin
						if (take_max) begin
							cur_max_q <= x_q;
							max_pos_q <= ws_q;
						end else if (hit_max) begin
							need_max_q <= 1'b1;
						end
						if (take_min) begin
							cur_min_q <= x_q;
							min_pos_q <= ws_q;
						end else if (hit_min) begin
							need_min_q <= 1'b1;
						end
						if ((!take_max && hit_max) || (!take_min && hit_min)) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_addr_q <= scan_addr_q + 1'b1;
					if (scan_addr_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						cur_max_q   <= fin_max;
						cur_min_q   <= fin_min;
						max_pos_q   <= fin_max_pos;
						min_pos_q   <= fin_min_pos;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample;
		end
		first_s1 <= (scan_addr_q == '0);
		idx_s1   <= scan_addr_q;
		if (state_q == ST_DONE && out_free) begin
			out_sum_q     <= sum_q;
			out_max_q     <= fin_max;
			out_min_q     <= fin_min;
			out_max_pos_q <= fin_max_pos;
			out_min_pos_q <= fin_min_pos;
			out_count_q   <= filled_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_sum   = out_sum_q;
	assign window_max   = out_max_q;
	assign window_min   = out_min_q;
	assign max_slot     = SLOT_W'(out_max_pos_q);
	assign min_slot     = SLOT_W'(out_min_pos_q);
	assign sample_count = COUNT_W'(out_count_q);

`ifndef SYNTHESIS
	a_done_loads_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("finished result not presented");

	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> rd_valid_s1)
		else $error("last scan read missing");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (filled_q != '0))
		else $error("fill count not advanced");

	a_rescan_path: assert property (@(posedge clk) disable iff (!arst_n)
		((need_max_q || need_min_q) && state_q == ST_DONE) |->
		($past(state_q) == ST_DRAIN || $past(state_q) == ST_DONE))
		else $error("rescan result used without a full pass");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the sliding window sum, min and max core: predicts and checks every result beat
`timescale 1ns / 100ps
module tb_top;
	import swsmm_pkg::*;

	localparam int RING_DEPTH     = 64;
	localparam int RESULT_LATENCY = 3 + RING_DEPTH + 1;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [SUM_W-1:0]    sum;
		logic signed [SAMPLE_W-1:0] max_val;
		logic signed [SAMPLE_W-1:0] min_val;
		logic [SLOT_W-1:0]          max_at;
		logic [SLOT_W-1:0]          min_at;
		logic [COUNT_W-1:0]         count;
	} window_stats_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_wr_en   = 1'b0;
	logic                       cfg_wr_data = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample      = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [SUM_W-1:0]    window_sum;
	logic signed [SAMPLE_W-1:0] window_max;
	logic signed [SAMPLE_W-1:0] window_min;
	logic [SLOT_W-1:0]          max_slot;
	logic [SLOT_W-1:0]          min_slot;
	logic [COUNT_W-1:0]         sample_count;

	// window predictor state
	logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
	int                         wr_slot    = RING_DEPTH - 1;
	int                         filled     = 0;
	logic signed [SUM_W-1:0]    win_sum    = '0;
	logic signed [SAMPLE_W-1:0] win_max    = '0;
	logic signed [SAMPLE_W-1:0] win_min    = '0;
	logic [SLOT_W-1:0]          win_max_at = '0;
	logic [SLOT_W-1:0]          win_min_at = '0;
	logic                       track_on   = 1'b1;

	window_stats_t              pending_stats [$];
	logic signed [SAMPLE_W-1:0] last_sent     = '0;
	int                         send_idle_pct = 0;
	int                         stall_pct     = 0;
	logic                       hold_req      = 1'b0;
	logic                       hold_ack      = 1'b0;
	int                         hold_left     = 0;
	int                         quiet_cycles  = 0;
	int                         mismatches    = 0;

	sliding_window_sum_min_max_core #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_sum  (window_sum),
		.window_max  (window_max),
		.window_min  (window_min),
		.max_slot    (max_slot),
		.min_slot    (min_slot),
		.sample_count(sample_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic window_stats_t advance_window(input logic signed [SAMPLE_W-1:0] x);
		logic signed [SAMPLE_W-1:0] evicted;
		window_stats_t              stats;
		wr_slot = (wr_slot == RING_DEPTH - 1) ? 0 : wr_slot + 1;
		if (filled < RING_DEPTH) begin
			filled++;
		end
		evicted = ring_copy[wr_slot];
		ring_copy[wr_slot] = x;
		win_sum = win_sum + x - evicted;
		if (track_on) begin
			if (x > win_max) begin
				win_max    = x;
				win_max_at = SLOT_W'(wr_slot);
			end else if (evicted == win_max) begin
				// lowest slot wins a tie
				win_max    = ring_copy[0];
				win_max_at = '0;
				for (int i = 1; i < RING_DEPTH; i++) begin
					if (ring_copy[i] > win_max) begin
						win_max    = ring_copy[i];
						win_max_at = SLOT_W'(i);
					end
				end
			end
			if (x < win_min) begin
				win_min    = x;
				win_min_at = SLOT_W'(wr_slot);
			end else if (evicted == win_min) begin
				win_min    = ring_copy[0];
				win_min_at = '0;
				for (int i = 1; i < RING_DEPTH; i++) begin
					if (ring_copy[i] < win_min) begin
						win_min    = ring_copy[i];
						win_min_at = SLOT_W'(i);
					end
				end
			end
		end
		stats.sum     = win_sum;
		stats.max_val = win_max;
		stats.min_val = win_min;
		stats.max_at  = win_max_at;
		stats.min_at  = win_min_at;
		stats.count   = COUNT_W'(filled);
		return stats;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned sel;
		sel = $urandom_range(9);
		case (sel)
			0, 1, 2, 3: begin
				return $urandom;
			end
			4: begin
				return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			end
			5, 6: begin
				return $urandom_range(6) - 3;
			end
			7: begin
				// within about +-2^18
				return $signed({{14{$urandom_range(1) == 1}}, 18'($urandom)});
			end
			8: begin
				return last_sent;
			end
			default: begin
				return '0;
			end
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		sample    <= value;
		last_sent  = value;
		do @(posedge clk); while (in_stall);
		pending_stats.push_back(advance_window(value));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) begin
			@(posedge clk);
		end
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_tracking(input logic enable);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= enable;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		track_on   = enable;
	endtask

	task automatic test_directed_samples();
		logic signed [SAMPLE_W-1:0] picks [$];
		picks = '{32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh0001_0000,
			32'shFFFF_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFE,
			32'sh8000_0001, 32'sh0000_8000, 32'sh0000_0000, 32'shFFFF_FFFF};
		send_idle_pct = 0;
		stall_pct     = 0;
		foreach (picks[i]) begin
			send_sample(picks[i]);
		end
		wait_drained();
	endtask

	task automatic test_full_scale_window();
		// whole window at the positive rail, then the negative rail
		repeat (RING_DEPTH) send_sample(32'sh7FFF_FFFF);
		repeat (RING_DEPTH) send_sample(32'sh8000_0000);
		wait_drained();
	endtask

	task automatic test_tracking_toggle();
		write_tracking(1'b0);
		repeat (40) send_sample(pick_sample());
		wait_drained();
		write_tracking(1'b1);
		repeat (40) send_sample(pick_sample());
		wait_drained();
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
			input int items);
		send_idle_pct = sender_pct;
		stall_pct     = receiver_pct;
		repeat (items) send_sample(pick_sample());
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req     <= !hold_req;
		repeat (12) send_sample(pick_sample());
		wait_drained();
	endtask

	// result checker and receiver side
	always @(posedge clk) begin : result_check
		window_stats_t want;
		if (out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_stats.pop_front();
				if (window_sum !== want.sum)
					report_mismatch($sformatf("window_sum %0d, expected %0d",
						window_sum, want.sum));
				if (window_max !== want.max_val)
					report_mismatch($sformatf("window_max %0d, expected %0d",
						window_max, want.max_val));
				if (window_min !== want.min_val)
					report_mismatch($sformatf("window_min %0d, expected %0d",
						window_min, want.min_val));
				if (max_slot !== want.max_at)
					report_mismatch($sformatf("max_slot %0d, expected %0d",
						max_slot, want.max_at));
				if (min_slot !== want.min_at)
					report_mismatch($sformatf("min_slot %0d, expected %0d",
						min_slot, want.min_at));
				if (sample_count !== want.count)
					report_mismatch($sformatf("sample_count %0d, expected %0d",
						sample_count, want.count));
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		foreach (ring_copy[i]) begin
			ring_copy[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_samples();
		test_full_scale_window();
		test_tracking_toggle();
		test_random_traffic(0, 0, 280);
		test_random_traffic(58, 0, 280);
		test_random_traffic(0, 58, 280);
		test_random_traffic(22, 22, 280);
		test_backpressure();

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/swsmm_pkg.sv
design/swsmm_ring.sv
design/swsmm_scan.sv
design/sliding_window_sum_min_max_core.sv
dv/tb_top.sv
